@@ hw/rtl/xpio_pkg.sv @@
`timescale 1ns / 1ps

package xpio_pkg;

    localparam int MAX_INSN_BYTES_DEF = 15;
    localparam int BITMAP_PORTS_DEF   = 1024;
    localparam int QUEUE_DEPTH        = 2;

    // result status codes
    localparam logic [2:0] ST_EMULATED = 3'd0;
    localparam logic [2:0] ST_NOT_GPF  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_DENIED   = 3'd4;

    // item kinds on the input tuser
    localparam logic OP_INSN_BYTE = 1'b0;
    localparam logic OP_BITMAP_WR = 1'b1;

    // prefix and width codes
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_REP    = 8'hf3;
    localparam logic [1:0] WC_BYTE    = 2'd0;
    localparam logic [1:0] WC_WORD    = 2'd1;
    localparam logic [1:0] WC_DWORD   = 2'd2;

    // decoded instruction handed from front to back
    typedef struct packed {
        logic [2:0]  status;
        logic        is_output;
        logic [1:0]  width_code;
        logic [15:0] port;
        logic [4:0]  insn_length;
        logic        is_string;
        logic        rep;
        logic        df;
        logic [31:0] cx;
    } xpio_rec_t;

    function automatic logic is_prefix(input logic [7:0] b);
        return b inside {PFX_OPSIZE, PFX_REP, 8'h67, 8'h26, 8'h2e, 8'h36, 8'h3e,
                         8'h64, 8'h65, 8'hf0};
    endfunction

    function automatic logic is_io_opcode(input logic [7:0] b);
        return b inside {[8'h6c:8'h6f], [8'he4:8'he7], [8'hec:8'hef]};
    endfunction

endpackage

@@ hw/rtl/xpio_front.sv @@
`timescale 1ns / 1ps

module xpio_front #(
    parameter int MAX_INSN_BYTES = xpio_pkg::MAX_INSN_BYTES_DEF,
    parameter int BITMAP_PORTS   = xpio_pkg::BITMAP_PORTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic [7:0]          insn_byte,
    input  logic                first_byte,
    input  logic                is_gpf,
    input  logic [15:0]         dx_value,
    input  logic [31:0]         cx_value,
    input  logic                direction_flag,
    input  logic                full_access,
    input  logic [4:0]          bitmap_index,
    input  logic [31:0]         bitmap_word,
    output logic                push,
    output xpio_pkg::xpio_rec_t rec
);

    localparam int BITMAP_WORDS = (BITMAP_PORTS + 31) / 32;
    // only the first 32 words are reachable through a 5-bit index
    localparam int STORE_WORDS  = (BITMAP_WORDS < 32) ? BITMAP_WORDS : 32;
    localparam int STORE_BITS   = STORE_WORDS * 32;
    localparam int IDXW         = $clog2(STORE_BITS);

    logic [STORE_BITS-1:0] bm_reg, bm_next;
    logic                  dec_reg, dec_next;
    logic [4:0]            bs_reg, bs_next;
    logic                  sz_reg, sz_next;
    logic                  rep_reg, rep_next;
    logic [7:0]            opc_reg, opc_next;
    logic                  aw_reg, aw_next;

    logic                  live;
    logic                  fin;
    logic [15:0]           fin_port;
    logic [4:0]            fin_len;
    logic [7:0]            fin_opc;
    logic [4:0]            bs_inc;
    logic                  simple;
    logic [2:0]            simple_status;
    logic [4:0]            simple_len;

    logic [1:0]            width;
    logic [STORE_BITS+3:0] bm_ext;
    logic [IDXW-1:0]       pidx;
    logic                  in_store;
    logic [3:0]            window;
    logic [3:0]            need;
    logic [16:0]           port_end;
    logic                  permit_ok;

    always_comb
    begin
        bm_next       = bm_reg;
        dec_next      = dec_reg;
        bs_next       = bs_reg;
        sz_next       = sz_reg;
        rep_next      = rep_reg;
        opc_next      = opc_reg;
        aw_next       = aw_reg;
        live          = 1'b0;
        fin           = 1'b0;
        fin_port      = dx_value;
        fin_len       = bs_reg;
        fin_opc       = opc_reg;
        bs_inc        = bs_reg;
        simple        = 1'b0;
        simple_status = xpio_pkg::ST_NOT_GPF;
        simple_len    = '0;

        if (accept && op == xpio_pkg::OP_BITMAP_WR)
        begin
            for (int w = 0; w < STORE_WORDS; w++)
            begin
                if (bitmap_index == 5'(w))
                begin
                    bm_next[w*32 +: 32] = bitmap_word;
                end
            end
        end
        else if (accept)
        begin
            live = dec_reg;
            if (first_byte)
            begin
                dec_next = 1'b1;
                bs_next  = '0;
                sz_next  = 1'b0;
                rep_next = 1'b0;
                opc_next = '0;
                aw_next  = 1'b0;
                live     = is_gpf;
                if (!is_gpf)
                begin
                    simple        = 1'b1;
                    simple_status = xpio_pkg::ST_NOT_GPF;
                    simple_len    = '0;
                    dec_next      = 1'b0;
                end
            end
            bs_inc = bs_next + 5'd1;
            if (live)
            begin
                if (aw_next)
                begin
                    fin      = 1'b1;
                    fin_port = {8'h00, insn_byte};
                    fin_len  = bs_inc;
                    fin_opc  = opc_next;
                end
                else if (xpio_pkg::is_prefix(insn_byte))
                begin
                    if (insn_byte == xpio_pkg::PFX_OPSIZE)
                    begin
                        sz_next = 1'b1;
                    end
                    if (insn_byte == xpio_pkg::PFX_REP)
                    begin
                        rep_next = 1'b1;
                    end
                    bs_next = bs_inc;
                    if (bs_inc >= 5'(MAX_INSN_BYTES))
                    begin
                        simple        = 1'b1;
                        simple_status = xpio_pkg::ST_TOO_LONG;
                        simple_len    = bs_inc;
                        dec_next      = 1'b0;
                        aw_next       = 1'b0;
                    end
                end
                else if (!xpio_pkg::is_io_opcode(insn_byte))
                begin
                    simple        = 1'b1;
                    simple_status = xpio_pkg::ST_UNKNOWN;
                    simple_len    = bs_next;
                    dec_next      = 1'b0;
                    aw_next       = 1'b0;
                end
                else
                begin
                    opc_next = insn_byte;
                    bs_next  = bs_inc;
                    if (!insn_byte[3])
                    begin
                        aw_next = 1'b1;
                    end
                    else
                    begin
                        fin      = 1'b1;
                        fin_port = dx_value;
                        fin_len  = bs_inc;
                        fin_opc  = insn_byte;
                    end
                end
                if (fin)
                begin
                    dec_next = 1'b0;
                    aw_next  = 1'b0;
                end
            end
        end
    end

    // permit check over the bytes of the access
    always_comb
    begin
        if (!fin_opc[0])
        begin
            width = xpio_pkg::WC_BYTE;
        end
        else if (sz_next)
        begin
            width = xpio_pkg::WC_WORD;
        end
        else
        begin
            width = xpio_pkg::WC_DWORD;
        end
        case (width)
            xpio_pkg::WC_BYTE: need = 4'b0001;
            xpio_pkg::WC_WORD: need = 4'b0011;
            default:           need = 4'b1111;
        endcase
        bm_ext    = {4'b0000, bm_reg};
        pidx      = fin_port[IDXW-1:0];
        in_store  = {1'b0, fin_port} < 17'(STORE_BITS);
        window    = in_store ? bm_ext[pidx +: 4] : 4'b0000;
        port_end  = {1'b0, fin_port} + 17'(4'b0001 << width);
        permit_ok = full_access ||
                    ((port_end <= 17'(BITMAP_PORTS)) && ((window & need) == need));
    end

    always_comb
    begin
        rec = '0;
        if (fin)
        begin
            rec.status      = permit_ok ? xpio_pkg::ST_EMULATED : xpio_pkg::ST_DENIED;
            rec.is_output   = fin_opc[1];
            rec.width_code  = width;
            rec.port        = fin_port;
            rec.insn_length = fin_len;
            rec.is_string   = !fin_opc[7];
            rec.rep         = rep_next;
            rec.df          = direction_flag;
            rec.cx          = cx_value;
        end
        else
        begin
            rec.status      = simple_status;
            rec.insn_length = simple_len;
        end
    end

    assign push = fin || simple;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bm_reg  <= '0;
            dec_reg <= 1'b0;
            bs_reg  <= '0;
            sz_reg  <= 1'b0;
            rep_reg <= 1'b0;
            opc_reg <= '0;
            aw_reg  <= 1'b0;
        end
        else
        begin
            bm_reg  <= bm_next;
            dec_reg <= dec_next;
            bs_reg  <= bs_next;
            sz_reg  <= sz_next;
            rep_reg <= rep_next;
            opc_reg <= opc_next;
            aw_reg  <= aw_next;
        end
    end

endmodule

@@ hw/rtl/xpio_queue.sv @@
`timescale 1ns / 1ps

module xpio_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  xpio_pkg::xpio_rec_t push_rec,
    input  logic                pop,
    output logic                full,
    output logic                valid,
    output xpio_pkg::xpio_rec_t head
);

    localparam int PW = (xpio_pkg::QUEUE_DEPTH > 1) ? $clog2(xpio_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(xpio_pkg::QUEUE_DEPTH + 1);

    xpio_pkg::xpio_rec_t slot_reg [xpio_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       wr_reg, wr_next;
    logic [PW-1:0]       rd_reg, rd_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(xpio_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full  = cnt_reg == CW'(xpio_pkg::QUEUE_DEPTH);
    assign valid = cnt_reg != '0;
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(xpio_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("queue count lost a push");
`endif

endmodule

@@ hw/rtl/xpio_back.sv @@
`timescale 1ns / 1ps

module xpio_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  xpio_pkg::xpio_rec_t q_head,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [2:0]          status,
    output logic                is_output,
    output logic [1:0]          width_code,
    output logic [15:0]         port,
    output logic [4:0]          insn_length,
    output logic [31:0]         pointer_delta,
    output logic                clear_count,
    output logic [31:0]         ax_or_mask
);

    logic        valid_reg;
    logic [2:0]  status_reg, status_next;
    logic        is_out_reg, is_out_next;
    logic [1:0]  width_reg, width_next;
    logic [15:0] port_reg, port_next;
    logic [4:0]  len_reg, len_next;
    logic [31:0] delta_reg, delta_next;
    logic        clr_reg, clr_next;
    logic [31:0] mask_reg, mask_next;

    logic        emulated;
    logic        keep;
    logic [31:0] mag;

    assign pop = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        emulated    = q_head.status == xpio_pkg::ST_EMULATED;
        keep        = emulated || q_head.status == xpio_pkg::ST_DENIED;
        status_next = q_head.status;
        is_out_next = keep ? q_head.is_output : 1'b0;
        width_next  = keep ? q_head.width_code : xpio_pkg::WC_BYTE;
        port_next   = keep ? q_head.port : '0;
        len_next    = q_head.insn_length;
        // byte count times CX is a shift by the width code
        mag         = q_head.rep ? (q_head.cx << q_head.width_code)
                                 : (32'd1 << q_head.width_code);
        delta_next  = '0;
        clr_next    = 1'b0;
        mask_next   = '0;
        if (emulated && q_head.is_string)
        begin
            delta_next = q_head.df ? (32'd0 - mag) : mag;
            clr_next   = q_head.rep;
        end
        else if (emulated && !q_head.is_output)
        begin
            case (q_head.width_code)
                xpio_pkg::WC_BYTE: mask_next = 32'h0000_00ff;
                xpio_pkg::WC_WORD: mask_next = 32'h0000_ffff;
                default:           mask_next = 32'hffff_ffff;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            is_out_reg <= is_out_next;
            width_reg  <= width_next;
            port_reg   <= port_next;
            len_reg    <= len_next;
            delta_reg  <= delta_next;
            clr_reg    <= clr_next;
            mask_reg   <= mask_next;
        end
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign is_output     = is_out_reg;
    assign width_code    = width_reg;
    assign port          = port_reg;
    assign insn_length   = len_reg;
    assign pointer_delta = delta_reg;
    assign clear_count   = clr_reg;
    assign ax_or_mask    = mask_reg;

endmodule

@@ hw/rtl/x86_port_io_insn_decoder.sv @@
// A result is registered in the queue, then in the back's output register, before it is shown.
// Throughput: one item per cycle while the queue is not full; the front updates decode state on each accepted item.
// The two-entry queue between front and back holds one result in steady flow,
// so s_axis_tready drops only once an output stall has filled the second entry too.
// Reset (rst_n low, async): decode state, permit bitmap (no port allowed),
// queue and output valid are cleared; no pass is needed after reset.
`timescale 1ns / 1ps

module x86_port_io_insn_decoder #(
    parameter int MAX_INSN_BYTES = xpio_pkg::MAX_INSN_BYTES_DEF,
    parameter int BITMAP_PORTS   = xpio_pkg::BITMAP_PORTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // insn_byte, first_byte, is_gpf, dx_value, cx_value, direction_flag,
    // full_access, bitmap_index, bitmap_word, zero fill
    input  logic [103:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // is_output, width_code, port, insn_length, pointer_delta, clear_count,
    // ax_or_mask, zero fill
    output logic [95:0]  m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    logic                accept;
    logic                push;
    xpio_pkg::xpio_rec_t push_rec;
    logic                q_full;
    logic                q_valid;
    logic                pop;
    xpio_pkg::xpio_rec_t q_head;

    logic [2:0]          status;
    logic                is_output;
    logic [1:0]          width_code;
    logic [15:0]         port;
    logic [4:0]          insn_length;
    logic [31:0]         pointer_delta;
    logic                clear_count;
    logic [31:0]         ax_or_mask;

    // the front never waits on the back except when the queue is full
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    xpio_front #(
        .MAX_INSN_BYTES (MAX_INSN_BYTES),
        .BITMAP_PORTS   (BITMAP_PORTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (s_axis_tuser),
        .insn_byte      (s_axis_tdata[7:0]),
        .first_byte     (s_axis_tdata[8]),
        .is_gpf         (s_axis_tdata[9]),
        .dx_value       (s_axis_tdata[25:10]),
        .cx_value       (s_axis_tdata[57:26]),
        .direction_flag (s_axis_tdata[58]),
        .full_access    (s_axis_tdata[59]),
        .bitmap_index   (s_axis_tdata[64:60]),
        .bitmap_word    (s_axis_tdata[96:65]),
        .push           (push),
        .rec            (push_rec)
    );

    xpio_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    xpio_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .pop           (pop),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .status        (status),
        .is_output     (is_output),
        .width_code    (width_code),
        .port          (port),
        .insn_length   (insn_length),
        .pointer_delta (pointer_delta),
        .clear_count   (clear_count),
        .ax_or_mask    (ax_or_mask)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {7'd0, ax_or_mask, clear_count, pointer_delta, insn_length,
                           port, width_code, is_output};

`ifndef SYNTHESIS
    // only an emulated access carries delta, CX clear or AX mask
    a_side_effects: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != xpio_pkg::ST_EMULATED) |->
        (pointer_delta == '0 && !clear_count && ax_or_mask == '0))
        else $error("side effect on a non-emulated result");
    // string forms never touch AX, non-string forms never move pointers
    a_delta_or_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pointer_delta == '0 || ax_or_mask == '0))
        else $error("both pointer delta and AX mask set");
    // a full queue must hold the input off
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready)
        else $error("input ready while queue full");
`endif

endmodule

@@ sim/tb_x86_port_io_insn_decoder.sv @@
`timescale 1ns / 1ps

module tb_x86_port_io_insn_decoder;

    // opcodes of the port I/O family
    localparam logic [7:0] OPC_INSB   = 8'h6c;
    localparam logic [7:0] OPC_INSD   = 8'h6d;
    localparam logic [7:0] OPC_OUTSB  = 8'h6e;
    localparam logic [7:0] OPC_OUTSD  = 8'h6f;
    localparam logic [7:0] OPC_IN_IB  = 8'he4;
    localparam logic [7:0] OPC_IN_ID  = 8'he5;
    localparam logic [7:0] OPC_OUT_IB = 8'he6;
    localparam logic [7:0] OPC_OUT_ID = 8'he7;
    localparam logic [7:0] OPC_IN_DB  = 8'hec;
    localparam logic [7:0] OPC_IN_DD  = 8'hed;
    localparam logic [7:0] OPC_OUT_DB = 8'hee;
    localparam logic [7:0] OPC_OUT_DD = 8'hef;

    // prefixes that only get skipped
    localparam logic [7:0] PFX_ADDR = 8'h67;
    localparam logic [7:0] PFX_ES   = 8'h26;
    localparam logic [7:0] PFX_CS   = 8'h2e;
    localparam logic [7:0] PFX_SS   = 8'h36;
    localparam logic [7:0] PFX_DS   = 8'h3e;
    localparam logic [7:0] PFX_FS   = 8'h64;
    localparam logic [7:0] PFX_GS   = 8'h65;
    localparam logic [7:0] PFX_LOCK = 8'hf0;
    localparam logic [7:0] BYTE_NOP = 8'h90;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 8;

    // one decoded result as it leaves the block
    typedef struct packed {
        logic [2:0]  status;
        logic        is_output;
        logic [1:0]  width_code;
        logic [15:0] port;
        logic [4:0]  insn_length;
        logic [31:0] pointer_delta;
        logic        clear_count;
        logic [31:0] ax_or_mask;
    } io_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [103:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tready = 1'b0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    x86_port_io_insn_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the decoder state
    logic [31:0] permits [32];
    bit          dec_active;
    int unsigned nbytes;
    bit          opsize;
    bit          rep;
    logic [7:0]  opcode;
    bit          want_port;

    io_result_t  pending_results [$];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [7:0]  hold_seq = '0;
    logic [7:0]  hold_seen;
    int          hold_left;

    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned n_emulated = 0;
    int unsigned n_denied = 0;
    int unsigned n_other = 0;
    int unsigned errors = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit known_prefix(input logic [7:0] b);
        case (b)
            xpio_pkg::PFX_OPSIZE, xpio_pkg::PFX_REP, PFX_ADDR, PFX_ES, PFX_CS, PFX_SS,
            PFX_DS, PFX_FS, PFX_GS, PFX_LOCK: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit port_io_opcode(input logic [7:0] b);
        return (b >= OPC_INSB && b <= OPC_OUTSD) || (b >= OPC_IN_IB && b <= OPC_OUT_ID)
            || (b >= OPC_IN_DB && b <= OPC_OUT_DD);
    endfunction

    function void push_plain(input logic [2:0] st, input logic [4:0] len);
        io_result_t r;
        r = '0;
        r.status = st;
        r.insn_length = len;
        pending_results.push_back(r);
        n_other++;
        dec_active = 1'b0;
        want_port = 1'b0;
    endfunction

    // completes an access: bitmap permission, then pointer delta / AX mask
    function void push_access(input logic [15:0] port, input logic [4:0] len,
                              input logic [31:0] cx, input logic df, input logic full);
        io_result_t  r;
        int unsigned nb;
        int unsigned p;
        int unsigned k;
        bit          ok;
        logic [31:0] mag;
        r = '0;
        r.is_output = opcode[1];
        r.width_code = !opcode[0] ? xpio_pkg::WC_BYTE :
                       (opsize ? xpio_pkg::WC_WORD : xpio_pkg::WC_DWORD);
        nb = 1 << r.width_code;
        r.port = port;
        r.insn_length = len;
        dec_active = 1'b0;
        want_port = 1'b0;
        ok = 1'b1;
        if (!full)
        begin
            ok = (int'(port) + nb) <= xpio_pkg::BITMAP_PORTS_DEF;
            for (k = 0; ok && k < nb; k++)
            begin
                p = port + k;
                if (!permits[5'(p >> 5)][5'(p)])
                    ok = 1'b0;
            end
        end
        if (!ok)
        begin
            r.status = xpio_pkg::ST_DENIED;
            n_denied++;
        end
        else
        begin
            r.status = xpio_pkg::ST_EMULATED;
            n_emulated++;
            if (!opcode[7])
            begin
                // string form; REP scales by the count and clears CX
                mag = rep ? nb * cx : nb;
                r.clear_count = rep;
                r.pointer_delta = df ? 32'd0 - mag : mag;
            end
            else if (!opcode[1])
                r.ax_or_mask = (r.width_code == xpio_pkg::WC_BYTE) ? 32'h0000_00ff :
                               (r.width_code == xpio_pkg::WC_WORD) ? 32'h0000_ffff :
                                                                     32'hffff_ffff;
        end
        pending_results.push_back(r);
    endfunction

    function void predict_item(input logic op, input logic [103:0] d);
        logic [7:0] b;
        b = d[7:0];
        if (op == xpio_pkg::OP_BITMAP_WR)
        begin
            permits[d[64:60]] = d[96:65];
            return;
        end
        if (d[8])
        begin
            // first byte always restarts decoding
            dec_active = 1'b1;
            nbytes = 0;
            opsize = 1'b0;
            rep = 1'b0;
            opcode = '0;
            want_port = 1'b0;
            if (!d[9])
            begin
                push_plain(xpio_pkg::ST_NOT_GPF, 5'd0);
                return;
            end
        end
        else if (!dec_active)
            return;
        if (want_port)
        begin
            push_access({8'h00, b}, 5'(nbytes + 1), d[57:26], d[58], d[59]);
            return;
        end
        if (known_prefix(b))
        begin
            if (b == xpio_pkg::PFX_OPSIZE)
                opsize = 1'b1;
            if (b == xpio_pkg::PFX_REP)
                rep = 1'b1;
            nbytes++;
            if (nbytes >= xpio_pkg::MAX_INSN_BYTES_DEF)
                push_plain(xpio_pkg::ST_TOO_LONG, 5'(nbytes));
            return;
        end
        if (!port_io_opcode(b))
        begin
            push_plain(xpio_pkg::ST_UNKNOWN, 5'(nbytes));
            return;
        end
        opcode = b;
        nbytes++;
        if (!b[3])
            want_port = 1'b1;
        else
            push_access(d[25:10], 5'(nbytes), d[57:26], d[58], d[59]);
    endfunction

    // ------------------------------------------------------------------
    // item helpers
    // ------------------------------------------------------------------
    // tdata from the lowest bit: insn_byte, first_byte, is_gpf, dx, cx, df,
    // full_access, bitmap_index, bitmap_word
    function automatic logic [103:0] pack_item(input logic [7:0] b, input logic first,
            input logic gpf, input logic [15:0] dx, input logic [31:0] cx, input logic df,
            input logic full, input logic [4:0] idx, input logic [31:0] word);
        return {7'b0, word, idx, full, df, cx, dx, gpf, first, b};
    endfunction

    task automatic send_item(input logic op, input logic [103:0] d);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_item(op, d);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first, input logic gpf,
                             input logic [15:0] dx, input logic [31:0] cx,
                             input logic df, input logic full);
        send_item(xpio_pkg::OP_INSN_BYTE, pack_item(b, first, gpf, dx, cx, df, full,
                                                    5'($urandom), $urandom));
    endtask

    task automatic send_permits(input logic [4:0] idx, input logic [31:0] word);
        send_item(xpio_pkg::OP_BITMAP_WR, pack_item(8'($urandom), 1'($urandom),
                                                    1'($urandom), 16'($urandom),
                                                    $urandom, 1'($urandom),
                                                    1'($urandom), idx, word));
    endtask

    // random byte with random side fields; ports mostly land in the bitmap range
    task automatic send_rand_byte(input logic [7:0] b, input logic first, input logic gpf);
        logic [15:0] dx;
        dx = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1060)) : 16'($urandom);
        send_byte(b, first, gpf, dx, $urandom, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 99) < 30);
    endtask

    function automatic logic [7:0] pick_prefix(input int k);
        case (k)
            0: return xpio_pkg::PFX_OPSIZE;
            1: return xpio_pkg::PFX_REP;
            2: return PFX_ADDR;
            3: return PFX_ES;
            4: return PFX_CS;
            5: return PFX_SS;
            6: return PFX_DS;
            7: return PFX_FS;
            8: return PFX_GS;
            default: return PFX_LOCK;
        endcase
    endfunction

    function automatic logic [7:0] pick_io_opcode(input int k);
        case (k)
            0: return OPC_INSB;
            1: return OPC_INSD;
            2: return OPC_OUTSB;
            3: return OPC_OUTSD;
            4: return OPC_IN_IB;
            5: return OPC_IN_ID;
            6: return OPC_OUT_IB;
            7: return OPC_OUT_ID;
            8: return OPC_IN_DB;
            9: return OPC_IN_DD;
            10: return OPC_OUT_DB;
            default: return OPC_OUT_DD;
        endcase
    endfunction

    // One instruction: prefixes, opcode, maybe a port byte. A few are broken:
    // overlong prefix runs, junk opcodes, a dropped port byte (next start
    // abandons it), non-gpf faults. Some are followed by a bitmap write or
    // a stray byte.
    task automatic send_rand_insn();
        int         npfx;
        int         k;
        logic       gpf;
        logic [7:0] opc;
        gpf = $urandom_range(0, 19) != 0;
        npfx = ($urandom_range(0, 99) < 4) ? $urandom_range(13, 16) : $urandom_range(0, 3);
        for (k = 0; k < npfx; k++)
            send_rand_byte(pick_prefix($urandom_range(0, 9)), k == 0, gpf);
        opc = ($urandom_range(0, 9) != 0) ? pick_io_opcode($urandom_range(0, 11))
                                          : 8'($urandom);
        send_rand_byte(opc, npfx == 0, gpf);
        if (!opc[3] && port_io_opcode(opc) && $urandom_range(0, 29) != 0)
            send_rand_byte(8'($urandom), 1'b0, gpf);
        k = $urandom_range(0, 99);
        if (k < 8)
            send_permits(5'($urandom), $urandom_range(0, 1) ? 32'hffff_ffff : 32'($urandom));
        else if (k < 11)
            send_rand_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_seen <= '0;
            hold_left <= 0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    function void report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        io_result_t want;
        io_result_t got;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            // tdata from the lowest bit: is_output, width_code, port,
            // insn_length, pointer_delta, clear_count, ax_or_mask
            got.status = m_axis_tuser;
            got.is_output = m_axis_tdata[0];
            got.width_code = m_axis_tdata[2:1];
            got.port = m_axis_tdata[18:3];
            got.insn_length = m_axis_tdata[23:19];
            got.pointer_delta = m_axis_tdata[55:24];
            got.clear_count = m_axis_tdata[56];
            got.ax_or_mask = m_axis_tdata[88:57];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("status", 32'(want.status), 32'(got.status));
                report_field("is_output", 32'(want.is_output), 32'(got.is_output));
                report_field("width_code", 32'(want.width_code), 32'(got.width_code));
                report_field("port", 32'(want.port), 32'(got.port));
                report_field("insn_length", 32'(want.insn_length), 32'(got.insn_length));
                report_field("pointer_delta", want.pointer_delta, got.pointer_delta);
                report_field("clear_count", 32'(want.clear_count), 32'(got.clear_count));
                report_field("ax_or_mask", want.ax_or_mask, got.ax_or_mask);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // Hand-picked instructions: empty bitmap after reset, edges of the
    // bitmap, all widths, REP with wrapping delta, DF set, non-gpf fault,
    // junk opcode, stray byte, restart mid-instruction, full access at the
    // top port, REP on a non-string form.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(OPC_IN_IB, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(8'h60, 1'b0, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_permits(5'd3, 32'hffff_ffff);
        send_permits(5'd31, 32'hffff_ffff);
        send_byte(OPC_IN_DB, 1'b1, 1'b1, 16'd1022, 32'd0, 1'b0, 1'b0);
        send_byte(xpio_pkg::PFX_OPSIZE, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_IN_DD, 1'b0, 1'b1, 16'd1022, 32'd0, 1'b0, 1'b0);
        // runs past the last port
        send_byte(OPC_IN_DD, 1'b1, 1'b1, 16'd1022, 32'd0, 1'b0, 1'b0);
        send_byte(xpio_pkg::PFX_REP, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_INSD, 1'b0, 1'b1, 16'd96, 32'hffff_ffff, 1'b1, 1'b0);
        send_byte(OPC_OUTSB, 1'b1, 1'b1, 16'd100, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_OUT_IB, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_IN_IB, 1'b1, 1'b0, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(PFX_ES, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(BYTE_NOP, 1'b0, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        // stray, ignored
        send_byte(BYTE_NOP, 1'b0, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_IN_IB, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_OUT_DD, 1'b1, 1'b1, 16'hffff, 32'hffff_ffff, 1'b1, 1'b1);
        send_byte(xpio_pkg::PFX_REP, 1'b1, 1'b1, 16'd0, 32'd0, 1'b0, 1'b0);
        send_byte(OPC_OUT_DB, 1'b0, 1'b1, 16'd992, 32'd5, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int unsigned n_items);
        int unsigned stop_at;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_rand_insn();
    endtask

    // receiver stops for a long stretch while items keep coming, so the
    // internal queue fills and the input side has to stall
    task automatic test_output_hold();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_seq <= hold_seq + 8'd1;
        for (k = 0; k < 30; k++)
            send_rand_insn();
    endtask

    task automatic wait_drained();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived: expected %0h, actual none",
                     $time, pending_results.size(), pending_results[0]);
            errors += pending_results.size();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        foreach (permits[i])
            permits[i] = '0;
        dec_active = 1'b0;
        nbytes = 0;
        opsize = 1'b0;
        rep = 1'b0;
        opcode = '0;
        want_port = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(0, 0, 480);
        test_random_traffic(59, 0, 460);
        test_random_traffic(0, 59, 460);
        test_random_traffic(25, 25, 460);
        test_output_hold();
        wait_drained();

        $display("Sent %0d items, checked %0d results (%0d emulated, %0d denied, %0d other).",
                 items_sent, results_seen, n_emulated, n_denied, n_other);
        $display("Covered prefixes, all opcodes, bitmap limits, REP/DF deltas and stalls.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
